>>> hdl/tta_pkg.sv
// Shared widths and constants for the tick-to-time accumulator.
// No dependencies; imported by tta_div and tick_to_time_accumulator_core.
`default_nettype none

package tta_pkg;

  localparam int COUNT_W    = 64;           // raw timer count
  localparam int DIVIDEND_W = COUNT_W + 1;  // delta plus leftover, with carry
  localparam int TOTAL_W    = 32;           // elapsed total, wraps
  localparam int TPU_W      = 10;           // ticks_per_us register
  localparam int DIVISOR_W  = 20;           // up to 1023 * 1000
  localparam int US_LEFT_W  = 10;
  localparam int MS_LEFT_W  = 20;
  localparam int DIV_STEPS  = DIVIDEND_W;   // one quotient bit per cycle
  localparam int STEP_W     = $clog2(DIV_STEPS);
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [TPU_W-1:0]       TICKS_RESET = 10'd24;
  localparam logic [TPU_W-1:0]       MS_FACTOR   = 10'd1000;
  localparam logic [ADDR_W-1:2]      REG_TICKS_PER_US = 1'b0;

endpackage

`default_nettype wire

>>> hdl/tick_to_time_accumulator_core.sv
// Tick-to-time accumulator: timer count samples to microsecond/millisecond totals.
// Each input transaction passes through the delta and sum prep states, the 65-step
// restoring divider in tta_div, the done state (held while the output register is
// full) and the output register update; one item at a time.
// Reset (rst, synchronous): both units' counts, leftovers and totals cleared,
// ticks_per_us set to 24, no output pending. Depends on tta_pkg and tta_div.
`default_nettype none

module tick_to_time_accumulator_core
  import tta_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // config port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready,
  // input stream
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [63:0]       s_tdata,   // [63:0] timer_count
  input  wire logic [0:0]        s_tuser,   // [0] unit_select
  // output stream
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [31:0]            m_tdata    // [31:0] elapsed_time
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DELTA = 5'b00010,
    ST_SUM   = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [TPU_W-1:0]     ticks_per_us;
  logic [COUNT_W-1:0]   us_last_count, ms_last_count;
  logic [US_LEFT_W-1:0] us_leftover_ticks;
  logic [MS_LEFT_W-1:0] ms_leftover_ticks;
  logic [TOTAL_W-1:0]   us_total, ms_total;

  logic [COUNT_W-1:0]   count_q;
  logic                 sel_q;
  logic [DIVISOR_W-1:0] divisor_q;
  logic [COUNT_W-1:0]   delta;

  logic [TPU_W-1:0]      tpu_eff;
  logic [DIVISOR_W-1:0]  divisor_new;
  logic [MS_LEFT_W-1:0]  left_sel;
  logic [DIVIDEND_W-1:0] dividend;
  logic [TOTAL_W-1:0]    total_next;
  logic                  out_free;
  logic                  cfg_write;

  logic                  div_start, div_busy, div_done;
  logic [TOTAL_W-1:0]    div_quot;
  logic [DIVISOR_W-1:0]  div_rem;

  // config register
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_us <= TICKS_RESET;
    end else if (cfg_write && paddr[ADDR_W-1:2] == REG_TICKS_PER_US) begin
      ticks_per_us <= pwdata[TPU_W-1:0];
    end
  end

  assign prdata = (paddr[ADDR_W-1:2] == REG_TICKS_PER_US)
                  ? {{(DATA_W-TPU_W){1'b0}}, ticks_per_us} : '0;

  // a zero divisor acts as one
  assign tpu_eff     = (ticks_per_us == '0) ? TPU_W'(1) : ticks_per_us;
  assign divisor_new = s_tuser[0] ? DIVISOR_W'(tpu_eff) * DIVISOR_W'(MS_FACTOR)
                                  : {{(DIVISOR_W-TPU_W){1'b0}}, tpu_eff};

  assign left_sel = sel_q ? ms_leftover_ticks
                          : {{(MS_LEFT_W-US_LEFT_W){1'b0}}, us_leftover_ticks};
  assign dividend = {1'b0, delta} + {{(DIVIDEND_W-MS_LEFT_W){1'b0}}, left_sel};

  assign total_next = (sel_q ? ms_total : us_total) + div_quot;
  assign out_free   = ~m_tvalid | m_tready;
  assign s_tready   = (state == ST_IDLE);
  assign div_start  = (state == ST_SUM);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_DELTA;
      ST_DELTA: state_next = ST_SUM;
      ST_SUM:   state_next = ST_DIV;
      ST_DIV:   if (div_done) state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // transaction capture and prep
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      count_q   <= s_tdata;
      sel_q     <= s_tuser[0];
      divisor_q <= divisor_new;
    end
    if (state == ST_DELTA) begin
      delta <= count_q - (sel_q ? ms_last_count : us_last_count);
    end
  end

  // per-unit state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      us_last_count     <= '0;
      us_leftover_ticks <= '0;
      us_total          <= '0;
      ms_last_count     <= '0;
      ms_leftover_ticks <= '0;
      ms_total          <= '0;
      m_tvalid          <= 1'b0;
    end else begin
      if (m_tready) m_tvalid <= 1'b0;
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
        if (sel_q) begin
          ms_last_count     <= count_q;
          ms_leftover_ticks <= div_rem[MS_LEFT_W-1:0];
          ms_total          <= total_next;
        end else begin
          us_last_count     <= count_q;
          us_leftover_ticks <= div_rem[US_LEFT_W-1:0];
          us_total          <= total_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) m_tdata <= total_next;
  end

  tta_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (dividend),
    .divisor   (divisor_q),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // checks
  a_ready_idle_div: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !div_busy)
    else $error("input ready while divider busy");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside divide state");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (div_rem < divisor_q))
    else $error("remainder not below divisor");

  a_start_from_delta: assert property (@(posedge clk) disable iff (rst)
    div_start |-> $past(state) == ST_DELTA)
    else $error("divider started without delta step");

endmodule

`default_nettype wire

>>> hdl/tta_div.sv
// Restoring divider, one quotient bit per cycle, 65-bit dividend by 20-bit divisor.
// Depends on tta_pkg.
`default_nettype none

module tta_div
  import tta_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       busy,
  output logic                       done,
  output logic [TOTAL_W-1:0]         quotient,
  output logic [DIVISOR_W-1:0]       remainder
);

  logic [DIVIDEND_W-1:0] dq;      // dividend bits shift out, quotient bits shift in
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvsr;
  logic [STEP_W-1:0]     step;

  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W+1:0]  trial;
  logic                  qbit;

  assign shifted = {rem, dq[DIVIDEND_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvsr};
  assign qbit    = ~trial[DIVISOR_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq   <= dividend;
      rem  <= '0;
      dvsr <= divisor;
    end else if (busy) begin
      dq  <= {dq[DIVIDEND_W-2:0], qbit};
      rem <= qbit ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
    end
  end

  assign quotient  = dq[TOTAL_W-1:0];
  assign remainder = rem;

endmodule

`default_nettype wire

>>> dv/tb_tick_to_time_accumulator_core.sv
// Testbench for tick_to_time_accumulator_core: drives timer samples and APB writes,
// predicts each elapsed total in-bench and checks the output stream in order.
// Depends on tta_pkg and the RTL under hdl/.
`timescale 1ns / 100ps

module tb_tick_to_time_accumulator_core
  import tta_pkg::*;
();

  typedef enum logic {UNIT_US = 1'b0, UNIT_MS = 1'b1} unit_t;

  localparam int IDLE_LIMIT   = 5000;  // cycles without any transaction
  localparam int DRAIN_CYCLES = 80;    // a bit over one item's latency
  localparam int HOLD_CYCLES  = 600;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [63:0]       s_tdata = '0;   // [63:0] timer_count
  logic [0:0]        s_tuser = '0;   // [0] unit_select
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [31:0]       m_tdata;        // [31:0] elapsed_time

  tick_to_time_accumulator_core u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // Mirror of the block's state
  logic [TPU_W-1:0]     tpu_q = TICKS_RESET;
  logic [COUNT_W-1:0]   us_last_q = '0;
  logic [US_LEFT_W-1:0] us_left_q = '0;
  logic [TOTAL_W-1:0]   us_total_q = '0;
  logic [COUNT_W-1:0]   ms_last_q = '0;
  logic [MS_LEFT_W-1:0] ms_left_q = '0;
  logic [TOTAL_W-1:0]   ms_total_q = '0;

  logic [TOTAL_W-1:0] expected_elapsed[$];
  logic [TOTAL_W-1:0] elapsed_exp;
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int recv_hold_left = 0;
  int quiet_cycles = 0;

  // Advances the selected unit by one sample and returns its new total.
  function automatic logic [TOTAL_W-1:0] advance_elapsed(input logic [COUNT_W-1:0] count,
                                                        input unit_t unit);
    logic [TPU_W-1:0]      tpu;
    logic [DIVISOR_W-1:0]  divisor;
    logic [DIVIDEND_W-1:0] sum;
    logic [DIVIDEND_W-1:0] quo;
    logic [DIVIDEND_W-1:0] rem;
    tpu = (tpu_q == '0) ? TPU_W'(1) : tpu_q;
    if (unit == UNIT_US) begin
      divisor = DIVISOR_W'(tpu);
      // 65-bit sum keeps the carry when delta is near 2^64
      sum = {1'b0, count - us_last_q} + DIVIDEND_W'(us_left_q);
    end else begin
      divisor = DIVISOR_W'(tpu) * DIVISOR_W'(MS_FACTOR);
      sum = {1'b0, count - ms_last_q} + DIVIDEND_W'(ms_left_q);
    end
    quo = sum / DIVIDEND_W'(divisor);
    rem = sum % DIVIDEND_W'(divisor);
    if (unit == UNIT_US) begin
      us_last_q  = count;
      us_left_q  = rem[US_LEFT_W-1:0];
      us_total_q = us_total_q + quo[TOTAL_W-1:0];
      return us_total_q;
    end else begin
      ms_last_q  = count;
      ms_left_q  = rem[MS_LEFT_W-1:0];
      ms_total_q = ms_total_q + quo[TOTAL_W-1:0];
      return ms_total_q;
    end
  endfunction

  // Entered and left at a falling edge; s_tvalid stays high for back-to-back items.
  task automatic send_sample(input logic [COUNT_W-1:0] count, input unit_t unit);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= count;
    s_tuser  <= unit;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_elapsed.push_back(advance_elapsed(count, unit));
    @(negedge clk);
  endtask

  // Sender pauses until every expected total has come back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_elapsed.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic set_ticks_per_us(input logic [TPU_W-1:0] value);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_TICKS_PER_US, 2'b00};
    pwdata  <= {(DATA_W-TPU_W)'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    tpu_q = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== DATA_W'(value)) begin
      $error("ticks_per_us readback: expected %0d, actual %0d", value, prdata);
      errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_count_extremes();
    send_sample(64'd0, UNIT_US);
    send_sample(64'd100, UNIT_US);
    send_sample(64'd72_005, UNIT_MS);
    send_sample('1, UNIT_US);
    send_sample('1, UNIT_MS);
    send_sample(64'd0, UNIT_US);   // wraps: delta of one
    send_sample(64'd0, UNIT_MS);
  endtask

  // delta of 2^64-1 plus a nonzero leftover overflows 64 bits
  task automatic test_sum_carry();
    set_ticks_per_us(10'd1000);
    send_sample(us_last_q + 64'd999, UNIT_US);
    if (us_left_q == '0) send_sample(us_last_q + 64'd1, UNIT_US);
    send_sample(us_last_q - 64'd1, UNIT_US);
    send_sample(ms_last_q + 64'd999_999, UNIT_MS);
    if (ms_left_q == '0) send_sample(ms_last_q + 64'd1, UNIT_MS);
    send_sample(ms_last_q - 64'd1, UNIT_MS);
  endtask

  // leftovers kept under one divisor are carried into the next
  task automatic test_divisor_change();
    set_ticks_per_us(10'd1000);
    send_sample(us_last_q + 64'd999, UNIT_US);
    send_sample(ms_last_q + 64'd999_999, UNIT_MS);
    set_ticks_per_us(10'd1);
    send_sample(us_last_q, UNIT_US);
    send_sample(ms_last_q, UNIT_MS);
    set_ticks_per_us(10'd1023);
    send_sample(us_last_q + 64'd1022, UNIT_US);
    send_sample(ms_last_q + 64'd1_022_999, UNIT_MS);
  endtask

  // a zero register value divides as one
  task automatic test_zero_divisor();
    set_ticks_per_us(10'd0);
    send_sample(us_last_q + 64'd5, UNIT_US);
    send_sample(ms_last_q + 64'd2_500, UNIT_MS);
  endtask

  task automatic test_random_traffic(input int n, input int send_pct, input int recv_pct,
                                     input logic [TPU_W-1:0] tpu);
    logic [COUNT_W-1:0] base;
    logic [COUNT_W-1:0] count;
    unit_t unit;
    int kind;
    set_ticks_per_us(tpu);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < n; i++) begin
      unit = unit_t'($urandom_range(1));
      base = (unit == UNIT_US) ? us_last_q : ms_last_q;
      kind = $urandom_range(99);
      if (kind < 40)      count = base + 64'($urandom_range(3000));
      else if (kind < 65) count = base + 64'($urandom_range(3_000_000));
      else if (kind < 80) count = base + 64'($urandom);
      else if (kind < 95) count = {$urandom, $urandom};
      else                count = base - 64'($urandom_range(4));
      send_sample(count, unit);
    end
  endtask

  // receiver stalls long enough for the input side to back up
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold_left = HOLD_CYCLES;
    for (int i = 0; i < 12; i++) begin
      send_sample(us_last_q + 64'($urandom_range(100_000)), unit_t'(i % 2));
    end
    drain_results();
  endtask

  always @(negedge clk) begin
    if (recv_hold_left != 0) begin
      m_tready <= 1'b0;
      recv_hold_left <= recv_hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_elapsed.size() == 0) begin
        $error("elapsed_time: no transaction expected, actual %0d", m_tdata);
        errors++;
      end else begin
        elapsed_exp = expected_elapsed.pop_front();
        if (m_tdata !== elapsed_exp) begin
          $error("elapsed_time: expected %0d, actual %0d", elapsed_exp, m_tdata);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_count_extremes();
    test_sum_carry();
    test_divisor_change();
    test_zero_divisor();
    test_random_traffic(155, 9, 78, 10'd1);
    test_random_traffic(155, 9, 78, 10'd1023);
    test_random_traffic(155, 9, 78, 10'($urandom_range(1023)));
    test_output_backpressure();
    test_random_traffic(155, 78, 9, 10'd1000);
    test_random_traffic(155, 78, 9, 10'd24);
    test_random_traffic(155, 78, 9, 10'($urandom_range(1023)));
    test_random_traffic(155, 0, 0, 10'd0);
    test_random_traffic(155, 0, 0, 10'd1);
    test_random_traffic(155, 0, 0, 10'($urandom_range(1023)));
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_elapsed.size() != 0) begin
      $error("elapsed_time: %0d transactions never arrived", expected_elapsed.size());
      errors++;
    end
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/tta_pkg.sv
hdl/tta_div.sv
hdl/tick_to_time_accumulator_core.sv
dv/tb_tick_to_time_accumulator_core.sv
